FILE: rtl/ihc_pkg.sv
// Shared types and constants for the IPv4 header check.
// Used by ihc_engine and ipv4_header_check; depends on nothing else.
package ihc_pkg;

  // Verdict codes, in priority order after the word 0 checks.
  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_HEADLEN  = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_CHECKSUM = 3'd4,
    VERDICT_DEST     = 3'd5
  } verdict_t;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ADDR_W  = 32;

  localparam logic [3:0]         IP_VERSION   = 4'd4;
  localparam logic [3:0]         MIN_IHL      = 4'd5;
  localparam logic [COUNT_W-1:0] TTL_WORD     = 5'd4;
  localparam logic [COUNT_W-1:0] DEST_HI_WORD = 5'd8;
  localparam logic [COUNT_W-1:0] DEST_LO_WORD = 5'd9;
  localparam logic [COUNT_W-1:0] MIN_WORDS    = 5'd10;
  localparam logic [WORD_W-1:0]  SUM_GOOD     = 16'hffff;
  localparam logic [ADDR_W-1:0]  BROADCAST    = 32'hffff_ffff;

  // One registered input item.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first;
  } ihc_item_t;

  // Result of one item: whether it closes a header, and the verdict.
  typedef struct packed {
    logic     valid;
    verdict_t verdict;
  } ihc_result_t;

endpackage

FILE: rtl/ihc_engine.sv
// Per-header state and verdict logic of the IPv4 header check.
// Depends on ihc_pkg for the item, result and verdict types.
module ihc_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  ihc_pkg::ihc_item_t           item,
  input  logic                         step,
  input  logic [ihc_pkg::ADDR_W-1:0]   own_address,
  output ihc_pkg::ihc_result_t         result
);

  logic                          in_header;
  logic [ihc_pkg::COUNT_W-1:0]   word_count;
  logic [ihc_pkg::COUNT_W-1:0]   header_words;
  logic [ihc_pkg::WORD_W-1:0]    running_sum;
  logic                          ttl_was_zero;
  logic [ihc_pkg::WORD_W-1:0]    dest_upper;
  logic                          dest_matched;

  logic                          in_header_next;
  logic [ihc_pkg::COUNT_W-1:0]   word_count_next;
  logic [ihc_pkg::COUNT_W-1:0]   header_words_next;
  logic [ihc_pkg::WORD_W-1:0]    running_sum_next;
  logic                          ttl_was_zero_next;
  logic [ihc_pkg::WORD_W-1:0]    dest_upper_next;
  logic                          dest_matched_next;

  logic [3:0]                    version;
  logic [3:0]                    ihl;
  logic [ihc_pkg::WORD_W:0]      raw_sum;
  logic [ihc_pkg::WORD_W-1:0]    folded_sum;
  logic [ihc_pkg::ADDR_W-1:0]    dest;
  logic [ihc_pkg::COUNT_W-1:0]   count_inc;

  assign version = item.word[15:12];
  assign ihl     = item.word[11:8];

  // Ones' complement add with end-around carry; the fold cannot carry again.
  assign raw_sum    = {1'b0, running_sum} + {1'b0, item.word};
  assign folded_sum = raw_sum[ihc_pkg::WORD_W-1:0] +
                      {{(ihc_pkg::WORD_W-1){1'b0}}, raw_sum[ihc_pkg::WORD_W]};

  assign dest      = {dest_upper, item.word};
  assign count_inc = word_count + 5'd1;

  // Next state and result for the item in the input register.
  always_comb begin
    in_header_next    = in_header;
    word_count_next   = word_count;
    header_words_next = header_words;
    running_sum_next  = running_sum;
    ttl_was_zero_next = ttl_was_zero;
    dest_upper_next   = dest_upper;
    dest_matched_next = dest_matched;
    result.valid      = 1'b0;
    result.verdict    = ihc_pkg::VERDICT_OK;

    if (item.first) begin
      in_header_next = 1'b0;
      if (version != ihc_pkg::IP_VERSION) begin
        result.valid   = 1'b1;
        result.verdict = ihc_pkg::VERDICT_VERSION;
      end else if (ihl < ihc_pkg::MIN_IHL) begin
        result.valid   = 1'b1;
        result.verdict = ihc_pkg::VERDICT_HEADLEN;
      end else begin
        in_header_next    = 1'b1;
        header_words_next = {ihl, 1'b0};
        word_count_next   = 5'd1;
        running_sum_next  = item.word;
        ttl_was_zero_next = 1'b0;
        dest_upper_next   = '0;
        dest_matched_next = 1'b0;
      end
    end else if (in_header) begin
      running_sum_next = folded_sum;
      if (word_count == ihc_pkg::TTL_WORD) begin
        ttl_was_zero_next = (item.word[15:8] == 8'd0);
      end else if (word_count == ihc_pkg::DEST_HI_WORD) begin
        dest_upper_next = item.word;
      end else if (word_count == ihc_pkg::DEST_LO_WORD) begin
        dest_matched_next = (dest == own_address) || (dest == ihc_pkg::BROADCAST);
      end
      word_count_next = count_inc;

      // Last summed word: give the verdict and go idle.
      if (count_inc >= header_words) begin
        in_header_next = 1'b0;
        result.valid   = 1'b1;
        if (ttl_was_zero_next) begin
          result.verdict = ihc_pkg::VERDICT_TTL;
        end else if (folded_sum != ihc_pkg::SUM_GOOD) begin
          result.verdict = ihc_pkg::VERDICT_CHECKSUM;
        end else if (!dest_matched_next) begin
          result.verdict = ihc_pkg::VERDICT_DEST;
        end else begin
          result.verdict = ihc_pkg::VERDICT_OK;
        end
      end
    end
  end

  // Header state registers, updated when the item is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b0;
      word_count   <= '0;
      header_words <= '0;
      running_sum  <= '0;
      ttl_was_zero <= 1'b0;
      dest_upper   <= '0;
      dest_matched <= 1'b0;
    end else if (step) begin
      in_header    <= in_header_next;
      word_count   <= word_count_next;
      header_words <= header_words_next;
      running_sum  <= running_sum_next;
      ttl_was_zero <= ttl_was_zero_next;
      dest_upper   <= dest_upper_next;
      dest_matched <= dest_matched_next;
    end
  end

  // A header in progress always has a legal length and unfinished count.
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    in_header |-> (header_words >= ihc_pkg::MIN_WORDS))
    else $error("header length below minimum while in a header");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    in_header |-> (word_count < header_words))
    else $error("word count reached header length without a verdict");

  // Verdicts on later words come only from a header in progress.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !item.first) |-> in_header)
    else $error("verdict given outside a header");

endmodule

FILE: rtl/ipv4_header_check.sv
// Top level of the IPv4 header check: input register, output register and
// the stream handshakes. Depends on ihc_pkg and ihc_engine.
//
// The block takes one 16-bit header word per cycle unless a verdict meets a
// stalled output, and gives one verdict per header: after the last of IHL*2
// words, or at once on word 0 for a bad version or a length below five. A
// word's verdict enters the output register as the word leaves the input
// register; the next word is taken in the same cycle as long as the output
// register is free or being read, or the input word gives no verdict. The
// sustained rate is thus one word per cycle, set by the single ones' complement
// add and the compares between the input and output registers. The user must
// write own_address only while no header is in flight; it is not enforced.
module ipv4_header_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ihc_pkg::ADDR_W-1:0]  cfg_wdata,    // own_address
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,      // [15:0] header_word
  input  logic                        s_tuser,      // [0] first_word
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,      // [2:0] verdict, [7:3] zero
  output logic                        m_tuser       // [0] accepted
);

  logic [ihc_pkg::ADDR_W-1:0] own_address;
  logic                       in_valid;
  ihc_pkg::ihc_item_t         in_item;
  logic                       out_valid;
  ihc_pkg::verdict_t          out_verdict;
  ihc_pkg::ihc_result_t       result;
  logic                       advance;
  logic                       out_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  // The item in the input register moves on unless its verdict finds the
  // output register full and stalled.
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && (out_free || !result.valid);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.word  <= s_tdata;
      in_item.first <= s_tuser;
    end
  end

  ihc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .item        (in_item),
    .step        (advance),
    .own_address (own_address),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.valid) begin
      out_verdict <= result.verdict;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_verdict};
  assign m_tuser  = (out_verdict == ihc_pkg::VERDICT_OK);

  // The input side only stalls when both registers hold work.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a full pipeline");

  // A verdict shown is one of the defined codes.
  a_verdict_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'd5))
    else $error("undefined verdict code on the output");

  // A stalled verdict is not overwritten by the next header's result.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled verdict was lost");

endmodule
